// ----- hw/rtl/b11_pkg.sv -----
// Package for the base-11 add, subtract and compare unit: sizes, codes, result type and helpers.
package b11_pkg;

    // Operand geometry.
    localparam int DIGITS  = 16;
    localparam int DIGIT_W = 4;
    localparam int WORD_W  = 64;
    localparam int LEN_W   = 5;
    localparam int LEVELS  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // Radix and the largest legal digit.
    localparam logic [DIGIT_W:0]   RADIX     = 11;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 10;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_CMP = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_INVALID   = 2'd2
    } status_t;

    // Everything the arithmetic unit produces for one item.
    typedef struct packed {
        logic [WORD_W-1:0] result_digits;
        logic              carry_digit;
        logic [LEN_W-1:0]  result_length;
        logic              is_less;
        logic              is_equal;
        logic              is_greater;
        status_t           status;
    } alu_res_t;

    // Digit count with leading zeros trimmed, never below one.
    function automatic logic [LEN_W-1:0] trim_length(input logic [WORD_W-1:0] word);
        logic [LEN_W-1:0] len;
        len = LEN_W'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            if (word[DIGIT_W*i +: DIGIT_W] != '0)
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// ----- hw/rtl/b11_alu.sv -----
// Combinational base-11 adder, subtractor and comparator with a parallel-prefix carry network.
module b11_alu (
    input  logic [1:0]                 opcode,
    input  logic [b11_pkg::WORD_W-1:0] a_digits,
    input  logic [b11_pkg::WORD_W-1:0] b_digits,
    output b11_pkg::alu_res_t          res
);
    import b11_pkg::*;

    // Generate and propagate per prefix level, for the sum and for the difference.
    logic [DIGITS-1:0] add_g [LEVELS+1];
    logic [DIGITS-1:0] add_p [LEVELS+1];
    logic [DIGITS-1:0] sub_g [LEVELS+1];
    logic [DIGITS-1:0] sub_p [LEVELS+1];
    logic              bad_digit;
    logic [WORD_W-1:0] sum_word;
    logic [WORD_W-1:0] dif_word;
    logic              sum_carry;
    logic              a_less;
    logic              a_equal;

    // Digit-level generate and propagate, then a Kogge-Stone prefix over the digits.
    always_comb
    begin
        logic [DIGIT_W-1:0] da;
        logic [DIGIT_W-1:0] db;
        int                 span;
        bad_digit = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            da = a_digits[DIGIT_W*i +: DIGIT_W];
            db = b_digits[DIGIT_W*i +: DIGIT_W];
            if (da > MAX_DIGIT || db > MAX_DIGIT)
            begin
                bad_digit = 1'b1;
            end
            add_g[0][i] = ((DIGIT_W+1)'(da) + (DIGIT_W+1)'(db)) >= RADIX;
            add_p[0][i] = ((DIGIT_W+1)'(da) + (DIGIT_W+1)'(db)) == (DIGIT_W+1)'(MAX_DIGIT);
            sub_g[0][i] = da < db;
            sub_p[0][i] = da == db;
        end
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            span = 1 << lvl;
            for (int i = 0; i < DIGITS; i++)
            begin
                if (i >= span)
                begin
                    add_g[lvl+1][i] = add_g[lvl][i] | (add_p[lvl][i] & add_g[lvl][i-span]);
                    add_p[lvl+1][i] = add_p[lvl][i] & add_p[lvl][i-span];
                    sub_g[lvl+1][i] = sub_g[lvl][i] | (sub_p[lvl][i] & sub_g[lvl][i-span]);
                    sub_p[lvl+1][i] = sub_p[lvl][i] & sub_p[lvl][i-span];
                end
                else
                begin
                    add_g[lvl+1][i] = add_g[lvl][i];
                    add_p[lvl+1][i] = add_p[lvl][i];
                    sub_g[lvl+1][i] = sub_g[lvl][i];
                    sub_p[lvl+1][i] = sub_p[lvl][i];
                end
            end
        end
    end

    // Carry out of the top digit, and the comparison taken from the final borrow.
    assign sum_carry = add_g[LEVELS][DIGITS-1];
    assign a_less    = sub_g[LEVELS][DIGITS-1];
    assign a_equal   = &sub_p[0];

    // Result digits: each digit uses the carry or borrow coming in from below.
    always_comb
    begin
        logic [DIGIT_W:0] da_x;
        logic [DIGIT_W:0] db_x;
        logic [DIGIT_W:0] sum_raw;
        logic [DIGIT_W:0] sub_in;
        logic             cin;
        logic             bin;
        sum_word = '0;
        dif_word = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            da_x = (DIGIT_W+1)'(a_digits[DIGIT_W*i +: DIGIT_W]);
            db_x = (DIGIT_W+1)'(b_digits[DIGIT_W*i +: DIGIT_W]);
            cin  = (i == 0) ? 1'b0 : add_g[LEVELS][i-1];
            bin  = (i == 0) ? 1'b0 : sub_g[LEVELS][i-1];
            sum_raw = da_x + db_x + (DIGIT_W+1)'(cin);
            if (sum_raw >= RADIX)
            begin
                sum_raw = sum_raw - RADIX;
            end
            sum_word[DIGIT_W*i +: DIGIT_W] = sum_raw[DIGIT_W-1:0];
            sub_in = db_x + (DIGIT_W+1)'(bin);
            if (da_x < sub_in)
            begin
                dif_word[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(da_x + RADIX - sub_in);
            end
            else
            begin
                dif_word[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(da_x - sub_in);
            end
        end
    end

    // Pick the result for the operation and apply the error cases.
    always_comb
    begin
        res.result_digits = '0;
        res.carry_digit   = 1'b0;
        res.result_length = LEN_W'(1);
        res.is_less       = a_less;
        res.is_equal      = a_equal;
        res.is_greater    = !a_less && !a_equal;
        res.status        = ST_OK;
        if (bad_digit)
        begin
            res.is_less    = 1'b0;
            res.is_equal   = 1'b0;
            res.is_greater = 1'b0;
            res.status     = ST_INVALID;
        end
        else
        begin
            case (op_t'(opcode))
                OP_ADD:
                begin
                    res.result_digits = sum_word;
                    res.carry_digit   = sum_carry;
                    res.result_length = sum_carry ? LEN_W'(DIGITS + 1) : trim_length(sum_word);
                end
                OP_SUB:
                begin
                    if (a_less)
                    begin
                        res.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        res.result_digits = dif_word;
                        res.result_length = trim_length(dif_word);
                    end
                end
                default:
                begin
                    // Compare only, and the unused opcode, keep the defaults.
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/base11_add_sub_compare_top.sv -----
// Top level of the base-11 add, subtract and compare unit: input register, arithmetic, result register.
//
// The unit takes one operation per clock cycle while in_stall is low and passes each through the input
// register and then the result register, in order, one result per operation. Operands are sixteen
// base-11 digits, least significant digit lowest. Between the input register and the result register
// sits a parallel-prefix carry network over the digits, which sets the clock period. A result waiting in
// the output register under stall stops the next operation only once the input register is also full.
module base11_add_sub_compare_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic [b11_pkg::WORD_W-1:0] a_digits,
    input  logic [b11_pkg::WORD_W-1:0] b_digits,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [b11_pkg::WORD_W-1:0] result_digits,
    output logic                       carry_digit,
    output logic [b11_pkg::LEN_W-1:0]  result_length,
    output logic                       is_less,
    output logic                       is_equal,
    output logic                       is_greater,
    output logic [1:0]                 status
);
    import b11_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [1:0]        op_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    alu_res_t          res_reg;
    alu_res_t          alu_res;
    logic              out_advance;
    logic              in_take;

    // The result register moves when it is empty or its transfer completes.
    assign out_advance = !out_valid_reg || !out_stall;
    assign in_stall    = in_valid_reg && !out_advance;
    assign in_take     = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_stall ? in_valid_reg : in_valid;
        out_valid_next = out_advance ? in_valid_reg : out_valid_reg;
    end

    // Valid flags of both registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operand register, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= opcode;
            a_reg  <= a_digits;
            b_reg  <= b_digits;
        end
    end

    b11_alu u_alu (
        .opcode   (op_reg),
        .a_digits (a_reg),
        .b_digits (b_reg),
        .res      (alu_res)
    );

    // Result register, loaded when an operand is present and the output can move.
    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            res_reg <= alu_res;
        end
    end

    // Output drive.
    assign out_valid     = out_valid_reg;
    assign result_digits = res_reg.result_digits;
    assign carry_digit   = res_reg.carry_digit;
    assign result_length = res_reg.result_length;
    assign is_less       = res_reg.is_less;
    assign is_equal      = res_reg.is_equal;
    assign is_greater    = res_reg.is_greater;
    assign status        = res_reg.status;

    // An operand that leaves the input register always lands in the result register.
    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_stall |=> out_valid)
        else $error("operand lost between input and result register");

    // Valid operands give exactly one comparison flag.
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_INVALID |-> $onehot({is_less, is_equal, is_greater}))
        else $error("comparison flags not one-hot");

    // Invalid digits clear the result.
    a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INVALID |->
            result_digits == '0 && result_length == LEN_W'(1) && !carry_digit)
        else $error("invalid-digit result not cleared");

    // A carry digit makes the result one digit longer than the operands.
    a_carry_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && carry_digit |-> result_length == LEN_W'(DIGITS + 1))
        else $error("carry digit with wrong length");

    // Underflow only when the first operand is the smaller.
    a_underflow_less: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_UNDERFLOW |-> is_less && result_digits == '0)
        else $error("underflow status without less flag");

endmodule

// ----- sim/tb_base11_add_sub_compare_top.sv -----
// Testbench for the base-11 add, subtract and compare unit: directed table, random items, checking.
`timescale 1ns / 100ps

module tb_base11_add_sub_compare_top;

    import b11_pkg::*;

    // The spare opcode behaves as compare only.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [WORD_W-1:0] ALL_TENS = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam int                HOLD_CYCLES = 80;
    localparam int                PRINT_LIMIT = 40;

    // One row of directed stimulus; typed rows carry their result, the rest are predicted.
    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              typed;
        alu_res_t          res;
    } stim_row_t;

    localparam int N_DIRECTED = 23;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // Zero plus zero straight after reset.
        '{OP_ADD, 64'h0, 64'h0, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b1, 1'b0, ST_OK}},
        // Largest operands: carry out of every digit.
        '{OP_ADD, ALL_TENS, ALL_TENS, 1'b1,
          '{64'hAAAA_AAAA_AAAA_AAA9, 1'b1, 5'd17, 1'b0, 1'b1, 1'b0, ST_OK}},
        '{OP_ADD, ALL_TENS, 64'h1, 1'b1,
          '{64'h0, 1'b1, 5'd17, 1'b0, 1'b0, 1'b1, ST_OK}},
        '{OP_SUB, ALL_TENS, ALL_TENS, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b1, 1'b0, ST_OK}},
        '{OP_SUB, ALL_TENS, 64'h0, 1'b1,
          '{ALL_TENS, 1'b0, 5'd16, 1'b0, 1'b0, 1'b1, ST_OK}},
        // Subtraction underflow.
        '{OP_SUB, 64'h0, 64'h1, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b1, 1'b0, 1'b0, ST_UNDERFLOW}},
        // Eleven minus one borrows from the second digit.
        '{OP_SUB, 64'h10, 64'h1, 1'b1,
          '{64'hA, 1'b0, 5'd1, 1'b0, 1'b0, 1'b1, ST_OK}},
        // Compare only, and the spare opcode.
        '{OP_CMP, ALL_TENS, 64'h0, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b1, ST_OK}},
        '{OP_CMP, 64'h0, ALL_TENS, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{OP_SPARE, 64'h0, ALL_TENS, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{OP_SPARE, 64'h5, 64'h5, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b1, 1'b0, ST_OK}},
        // Digits above ten, for every opcode.
        '{OP_ADD, 64'hB, 64'h0, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b0, ST_INVALID}},
        '{OP_SUB, 64'h0, 64'hB000_0000_0000_0000, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b0, ST_INVALID}},
        '{OP_CMP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b0, ST_INVALID}},
        '{OP_SPARE, 64'hA0, 64'hC00, 1'b1,
          '{64'h0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b0, ST_INVALID}},
        // Carry and borrow chains, trimming and near-equal compares.
        '{OP_ADD, 64'h0000_0000_00AA_AAAA, 64'h1, 1'b0, '0},
        '{OP_SUB, 64'h1000_0000_0000_0000, 64'h1, 1'b0, '0},
        '{OP_ADD, 64'h5, 64'h4, 1'b0, '0},
        '{OP_SUB, 64'hA000_0000_0000_0000, 64'h0A00_0000_0000_0000, 1'b0, '0},
        '{OP_ADD, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{OP_ADD, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5556, 1'b0, '0},
        '{OP_SUB, 64'h1, 64'h2, 1'b0, '0},
        '{OP_CMP, 64'h100, 64'hAA, 1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          opcode;
    logic [WORD_W-1:0]   a_digits;
    logic [WORD_W-1:0]   b_digits;
    logic                out_valid;
    logic                out_stall;
    logic [WORD_W-1:0]   result_digits;
    logic                carry_digit;
    logic [LEN_W-1:0]    result_length;
    logic                is_less;
    logic                is_equal;
    logic                is_greater;
    logic [1:0]          status;

    alu_res_t            pending_results[$];
    alu_res_t            oldest;
    int                  n_errors;
    int                  n_sent;
    int                  n_checked;
    int                  n_invalid;
    int                  n_underflow;
    int                  n_carry;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_asked;
    int                  hold_done;
    int                  hold_left;

    base11_add_sub_compare_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .a_digits      (a_digits),
        .b_digits      (b_digits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_digits (result_digits),
        .carry_digit   (carry_digit),
        .result_length (result_length),
        .is_less       (is_less),
        .is_equal      (is_equal),
        .is_greater    (is_greater),
        .status        (status)
    );

    // Clock, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of digits once leading zeros are dropped, never below one.
    function automatic logic [LEN_W-1:0] digits_in_use(input logic [WORD_W-1:0] word);
        logic [LEN_W-1:0] len;
        len = LEN_W'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            if (word[DIGIT_W*i +: DIGIT_W] != 0)
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

    // Expected result of one operation on two packed base-11 numbers.
    function automatic alu_res_t predict_base11(input logic [1:0] op,
                                                input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        alu_res_t r;
        logic     bad;
        int       order;
        int       da;
        int       db;
        int       sum;
        int       carry;
        int       borrow;
        r = '0;
        r.result_length = LEN_W'(1);
        r.status = ST_OK;
        bad = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (a[DIGIT_W*i +: DIGIT_W] > MAX_DIGIT || b[DIGIT_W*i +: DIGIT_W] > MAX_DIGIT)
            begin
                bad = 1'b1;
            end
        end
        if (bad)
        begin
            r.status = ST_INVALID;
            return r;
        end

        // Compare from the most significant digit down.
        order = 0;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            da = int'(a[DIGIT_W*i +: DIGIT_W]);
            db = int'(b[DIGIT_W*i +: DIGIT_W]);
            if (order == 0 && da < db)
            begin
                order = -1;
            end
            else if (order == 0 && da > db)
            begin
                order = 1;
            end
        end
        r.is_less    = (order < 0);
        r.is_equal   = (order == 0);
        r.is_greater = (order > 0);

        if (op == OP_ADD)
        begin
            carry = 0;
            for (int i = 0; i < DIGITS; i++)
            begin
                sum = int'(a[DIGIT_W*i +: DIGIT_W]) + int'(b[DIGIT_W*i +: DIGIT_W]) + carry;
                carry = sum / int'(RADIX);
                r.result_digits[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(sum % int'(RADIX));
            end
            r.carry_digit = (carry != 0);
            r.result_length = (carry != 0) ? LEN_W'(DIGITS + 1) : digits_in_use(r.result_digits);
        end
        else if (op == OP_SUB)
        begin
            if (order < 0)
            begin
                r.status = ST_UNDERFLOW;
            end
            else
            begin
                borrow = 0;
                for (int i = 0; i < DIGITS; i++)
                begin
                    da = int'(a[DIGIT_W*i +: DIGIT_W]);
                    db = int'(b[DIGIT_W*i +: DIGIT_W]) + borrow;
                    borrow = (da < db) ? 1 : 0;
                    r.result_digits[DIGIT_W*i +: DIGIT_W] =
                        DIGIT_W'(da + borrow * int'(RADIX) - db);
                end
                r.result_length = digits_in_use(r.result_digits);
            end
        end
        return r;
    endfunction

    // A legal number of random length: zero, all tens, or random digits.
    function automatic logic [WORD_W-1:0] random_number();
        logic [WORD_W-1:0] v;
        int                top;
        int                kind;
        v = '0;
        top = $urandom_range(DIGITS - 1);
        kind = $urandom_range(9);
        for (int i = 0; i <= top; i++)
        begin
            if (kind == 0)
            begin
                v[DIGIT_W*i +: DIGIT_W] = MAX_DIGIT;
            end
            else if (kind != 1)
            begin
                v[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(int'(MAX_DIGIT)));
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (n_errors < PRINT_LIMIT)
        begin
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        n_errors++;
    endtask

    // Offer one operation, wait for its transfer, then note what it should give.
    task automatic send_op(input logic [1:0] op, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b, input alu_res_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        opcode   = op;
        a_digits = a;
        b_digits = b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_results = {pending_results, want};
        n_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every transfer has given its result.
    task automatic wait_all_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Change the idling pattern while the block is empty; written away from the falling edge.
    task automatic set_idling(input int send_pct, input int recv_pct, input logic hold);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
        begin
            hold_asked++;
        end
        @(negedge clk);
    endtask

    // Receiver stall, with an occasional long hold-off counted here.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_done != hold_asked)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_asked;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result transfer", result_digits, '0);
            end
            else
            begin
                oldest = pending_results.pop_front();
                n_checked++;
                if (oldest.status == ST_INVALID)
                begin
                    n_invalid++;
                end
                if (oldest.status == ST_UNDERFLOW)
                begin
                    n_underflow++;
                end
                if (oldest.carry_digit)
                begin
                    n_carry++;
                end
                if (result_digits !== oldest.result_digits)
                    report_mismatch("result_digits", result_digits, oldest.result_digits);
                if (carry_digit !== oldest.carry_digit)
                    report_mismatch("carry_digit", WORD_W'(carry_digit),
                                    WORD_W'(oldest.carry_digit));
                if (result_length !== oldest.result_length)
                    report_mismatch("result_length", WORD_W'(result_length),
                                    WORD_W'(oldest.result_length));
                if (is_less !== oldest.is_less)
                    report_mismatch("is_less", WORD_W'(is_less), WORD_W'(oldest.is_less));
                if (is_equal !== oldest.is_equal)
                    report_mismatch("is_equal", WORD_W'(is_equal), WORD_W'(oldest.is_equal));
                if (is_greater !== oldest.is_greater)
                    report_mismatch("is_greater", WORD_W'(is_greater),
                                    WORD_W'(oldest.is_greater));
                if (status !== oldest.status)
                    report_mismatch("status", WORD_W'(status), WORD_W'(oldest.status));
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("FAIL base11_add_sub_compare_top");
        $finish;
    end

    // Stimulus: directed table, back-pressure burst, then random items in four idling phases.
    initial
    begin
        logic [1:0]        op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] swap;
        alu_res_t          want;
        int                pos;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_ADD;
        a_digits       = '0;
        b_digits       = '0;
        hold_asked     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n_errors       = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_invalid      = 0;
        n_underflow    = 0;
        n_carry        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            want = DIRECTED[i].typed ? DIRECTED[i].res
                                     : predict_base11(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b);
            send_op(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b, want);
        end
        wait_all_results();

        // Long receiver hold-off while the sender keeps offering, then phases of idling.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_idling(0, 0, 1'b1);
                1: set_idling(0, 0, 1'b0);
                2: set_idling(68, 0, 1'b0);
                3: set_idling(0, 68, 1'b0);
                default: set_idling(12, 12, 1'b0);
            endcase
            for (int k = 0; k < ((phase == 0) ? 60 : 360); k++)
            begin
                op = ($urandom_range(19) == 0) ? OP_SPARE : 2'($urandom_range(2));
                a = random_number();
                case ($urandom_range(9))
                    0, 1: b = a;
                    2:
                    begin
                        b = a;
                        pos = $urandom_range(DIGITS - 1);
                        b[DIGIT_W*pos +: DIGIT_W] = DIGIT_W'($urandom_range(int'(MAX_DIGIT)));
                    end
                    default: b = random_number();
                endcase
                // Packed legal digits order the same way as the words do.
                if (op == OP_SUB && a < b && $urandom_range(1) == 1)
                begin
                    swap = a;
                    a = b;
                    b = swap;
                end
                // Occasional digit above ten in either operand.
                if ($urandom_range(99) < 6)
                begin
                    pos = $urandom_range(DIGITS - 1);
                    if ($urandom_range(1) == 1)
                        a[DIGIT_W*pos +: DIGIT_W] = DIGIT_W'($urandom_range(15, 11));
                    else
                        b[DIGIT_W*pos +: DIGIT_W] = DIGIT_W'($urandom_range(15, 11));
                end
                send_op(op, a, b, predict_base11(op, a, b));
                if ($urandom_range(99) == 0)
                begin
                    wait_all_results();
                end
            end
            wait_all_results();
        end

        $display("Covered %0d transfers: directed cases, a long output hold-off and four idling",
                 n_sent);
        $display("phases; %0d invalid-digit, %0d underflow and %0d carry-out results checked.",
                 n_invalid, n_underflow, n_carry);
        if (n_errors == 0)
        begin
            $display("PASS base11_add_sub_compare_top");
        end
        else
        begin
            $display("%0d mismatches", n_errors);
            $display("FAIL base11_add_sub_compare_top");
        end
        $finish;
    end

endmodule
